// ===== hdl/mini_x86_instruction_executor_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the instruction executor
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MINI_X86_INSTRUCTION_EXECUTOR_UNIT_MACROS_SVH
`define MINI_X86_INSTRUCTION_EXECUTOR_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset
`define MXIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next
`define MXIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mxie_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxie_pkg
// Sizes, register indices, flag positions and opcodes of the executor.
// ----------------------------------------------------------------------------
package mxie_pkg;

    localparam int REG_COUNT   = 17;
    localparam int STACK_BYTES = 1024;
    localparam int ADDR_BITS   = $clog2(STACK_BYTES);
    localparam int ROW_BITS    = ADDR_BITS - 2;
    localparam int ROWS        = STACK_BYTES / 4;

    localparam logic [4:0] SP_REG   = 5'd6;
    localparam logic [4:0] FLAG_REG = 5'd16;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 6;
    localparam int FLAG_S = 7;
    localparam int FLAG_O = 11;

    // Register index of program_words on the configuration port
    localparam logic CFG_PROGRAM_WORDS = 1'b0;

    typedef enum logic [4:0] {
        OP_SUBL   = 5'd0,
        OP_ADD_RR = 5'd1,
        OP_ADD_IR = 5'd2,
        OP_IMULL  = 5'd3,
        OP_SHRL   = 5'd4,
        OP_MOV_RR = 5'd5,
        OP_LOAD   = 5'd6,
        OP_STORE  = 5'd7,
        OP_MOV_IR = 5'd8,
        OP_CMPL   = 5'd9,
        OP_JE     = 5'd10,
        OP_JL     = 5'd11,
        OP_JLE    = 5'd12,
        OP_JGE    = 5'd13,
        OP_JBE    = 5'd14,
        OP_JMP    = 5'd15,
        OP_CALL   = 5'd16,
        OP_RET    = 5'd17,
        OP_PUSHL  = 5'd18,
        OP_POPL   = 5'd19,
        OP_PRINTR = 5'd20,
        OP_READR  = 5'd21
    } op_t;

endpackage

// ===== hdl/mini_x86_instruction_executor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mini_x86_instruction_executor_unit
// Executes one instruction word per item against its own pc, register file
// and byte-wide stack, and returns one result item per instruction.
// ----------------------------------------------------------------------------
// An instruction is taken into an input register together with its two
// register operands, executed in one pass and written to a result register,
// so a new item is accepted every cycle while the result side keeps up and
// no stack read is under way. Load, pop and return from a non-empty stack
// add a read phase when their stack address is in range: the stack is four
// byte banks with a registered read port, and the word read there comes back
// in the cycle after its address. Every other operation, and every faulting
// one, needs no read phase. The stack needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "mini_x86_instruction_executor_unit_macros.svh"

module mini_x86_instruction_executor_unit
    import mxie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // instruction items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // instr_word[31:0], read_value[63:32]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // next_pc[31:0], print_valid[32],
                                   // print_value[64:33], halted[65], fault[66], zero
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [15:0] program_words_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_PROGRAM_WORDS) ? {16'd0, program_words_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_words_reg <= 16'd0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == CFG_PROGRAM_WORDS)
        begin
            program_words_reg <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [31:0] rf_reg [REG_COUNT];
    logic [31:0] pc_reg;

    // input stage
    logic        in_valid_reg;
    logic [31:0] instr_reg;
    logic [31:0] rv_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic        phase_reg;

    // result stage
    logic        out_valid_reg;
    logic [31:0] out_npc_reg;
    logic        out_pv_reg;
    logic [31:0] out_pval_reg;
    logic        out_halt_reg;
    logic        out_fault_reg;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    op_t         op;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [15:0] imm16;
    logic [31:0] immu;
    logic        need_a;
    logic        need_b;
    logic        reg_fault;

    assign op    = op_t'(instr_reg[31:27]);
    assign ra    = instr_reg[26:22];
    assign rb    = instr_reg[21:17];
    assign imm16 = instr_reg[15:0];
    assign immu  = {{16{imm16[15]}}, imm16};

    always_comb
    begin
        need_b = (op == OP_ADD_RR) || (op == OP_IMULL) || (op == OP_MOV_RR) ||
                 (op == OP_LOAD) || (op == OP_STORE) || (op == OP_CMPL);
        need_a = need_b || (instr_reg[31:27] <= 5'd4) || (op == OP_MOV_IR) ||
                 (op == OP_PUSHL) || (op == OP_POPL) || (op == OP_PRINTR) ||
                 (op == OP_READR);
    end

    assign reg_fault = (need_a && ({1'b0, ra} >= 6'(REG_COUNT))) ||
                       (need_b && ({1'b0, rb} >= 6'(REG_COUNT)));

    // ------------------------------------------------------------------
    // Stack address
    // ------------------------------------------------------------------
    logic [31:0] sp;
    logic [31:0] fl;
    logic [32:0] sp33;
    logic [32:0] imm33;
    logic [32:0] addr;
    logic        addr_ok;
    logic        sp_empty;

    assign sp       = rf_reg[SP_REG];
    assign fl       = rf_reg[FLAG_REG];
    assign sp33     = {sp[31], sp};
    assign imm33    = {{17{imm16[15]}}, imm16};
    assign sp_empty = (sp == 32'(STACK_BYTES));

    always_comb
    begin
        unique case (op)
            OP_LOAD:              addr = {a_reg[31], a_reg} + imm33;
            OP_STORE:             addr = {b_reg[31], b_reg} + imm33;
            OP_CALL, OP_PUSHL:    addr = sp33 - 33'd4;
            default:              addr = sp33;
        endcase
    end

    assign addr_ok = !addr[32] && (addr <= 33'(STACK_BYTES - 4));

    // ------------------------------------------------------------------
    // Stack memory: four byte banks, one row per bank per access
    // ------------------------------------------------------------------
    logic [1:0]          lo;
    logic [ROW_BITS-1:0] base_row;
    logic [ROW_BITS-1:0] mrow [4];
    logic [7:0]          wbyte [4];
    logic [7:0]          rbyte_reg [4];
    logic                mem_we;
    logic [31:0]         mem_wval;
    logic [31:0]         mem_rval;

    assign lo       = addr[1:0];
    assign base_row = addr[ADDR_BITS-1:2];

    for (genvar j = 0; j < 4; j++)
    begin : g_bank
        logic [7:0] bank_mem [ROWS];
        logic [1:0] k;

        assign k        = 2'(j) - lo;
        assign mrow[j]  = base_row + ROW_BITS'((2'(j) < lo) ? 1 : 0);
        assign wbyte[j] = 8'(mem_wval >> {k, 3'b000});

        always_ff @(posedge clk)
        begin
            if (mem_we)
            begin
                bank_mem[mrow[j]] <= wbyte[j];
            end
            rbyte_reg[j] <= bank_mem[mrow[j]];
        end
    end

    assign mem_rval = {rbyte_reg[2'(lo + 2'd3)], rbyte_reg[2'(lo + 2'd2)],
                       rbyte_reg[2'(lo + 2'd1)], rbyte_reg[lo]};

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    logic        is_read_op;
    logic        need_read;
    logic        out_free;
    logic        done;
    logic        accept;
    logic        wr0_en;
    logic [4:0]  wr0_idx;
    logic [31:0] wr0_data;
    logic        wr1_en;
    logic [31:0] wr1_data;
    logic [31:0] npc;
    logic        fault;
    logic        halt;
    logic        pv;
    logic [31:0] pval;
    logic [31:0] seq;
    logic [31:0] target;
    logic [31:0] mul_lo;
    logic [31:0] diff;
    logic        fc;
    logic        fz;
    logic        lt;

    assign seq    = pc_reg + 32'd4;
    assign target = seq + immu;
    assign mul_lo = a_reg * b_reg;
    assign diff   = b_reg - a_reg;
    assign fc     = fl[FLAG_C];
    assign fz     = fl[FLAG_Z];
    assign lt     = fl[FLAG_S] ^ fl[FLAG_O];

    assign is_read_op = (op == OP_LOAD) || (op == OP_POPL) || (op == OP_RET && !sp_empty);
    assign need_read  = in_valid_reg && !reg_fault && is_read_op && addr_ok && !phase_reg;
    assign out_free   = !out_valid_reg || m_tready;
    assign done       = in_valid_reg && !need_read && out_free;
    assign s_tready   = !in_valid_reg || done;
    assign accept     = s_tvalid && s_tready;

    always_comb
    begin
        wr0_en   = 1'b0;
        wr0_idx  = ra;
        wr0_data = 32'd0;
        wr1_en   = 1'b0;
        wr1_data = 32'd0;
        mem_we   = 1'b0;
        mem_wval = a_reg;
        npc      = seq;
        fault    = 1'b0;
        halt     = 1'b0;
        pv       = 1'b0;
        pval     = 32'd0;
        if (reg_fault)
        begin
            fault = 1'b1;
        end
        else
        begin
            unique case (op)
                OP_SUBL:   begin wr0_en = 1'b1; wr0_data = a_reg - immu; end
                OP_ADD_RR: begin wr0_en = 1'b1; wr0_idx = rb; wr0_data = a_reg + b_reg; end
                OP_ADD_IR: begin wr0_en = 1'b1; wr0_data = a_reg + immu; end
                OP_IMULL:  begin wr0_en = 1'b1; wr0_idx = rb; wr0_data = mul_lo; end
                OP_SHRL:   begin wr0_en = 1'b1; wr0_data = {1'b0, a_reg[31:1]}; end
                OP_MOV_RR: begin wr0_en = 1'b1; wr0_idx = rb; wr0_data = a_reg; end
                OP_LOAD:
                begin
                    if (addr_ok)
                    begin
                        wr0_en = 1'b1; wr0_idx = rb; wr0_data = mem_rval;
                    end
                    else
                    begin
                        fault = 1'b1;
                    end
                end
                OP_STORE:
                begin
                    if (addr_ok) mem_we = 1'b1;
                    else         fault  = 1'b1;
                end
                OP_MOV_IR: begin wr0_en = 1'b1; wr0_data = immu; end
                OP_CMPL:
                begin
                    wr0_en   = 1'b1;
                    wr0_idx  = FLAG_REG;
                    wr0_data = fl;
                    wr0_data[FLAG_C] = (b_reg < a_reg);
                    wr0_data[FLAG_Z] = (b_reg == a_reg);
                    wr0_data[FLAG_S] = diff[31];
                    wr0_data[FLAG_O] = (b_reg[31] != a_reg[31]) && (diff[31] != b_reg[31]);
                end
                OP_JE:  if (fz)        npc = target;
                OP_JL:  if (lt)        npc = target;
                OP_JLE: if (lt || fz)  npc = target;
                OP_JGE: if (!lt)       npc = target;
                OP_JBE: if (fc || fz)  npc = target;
                OP_JMP: npc = target;
                OP_CALL:
                begin
                    if (addr_ok)
                    begin
                        mem_we = 1'b1; mem_wval = seq;
                        wr1_en = 1'b1; wr1_data = addr[31:0];
                        npc    = target;
                    end
                    else
                    begin
                        fault = 1'b1;
                    end
                end
                OP_RET:
                begin
                    if (sp_empty)
                    begin
                        halt = 1'b1; npc = pc_reg;
                    end
                    else if (addr_ok)
                    begin
                        npc    = mem_rval;
                        wr1_en = 1'b1; wr1_data = sp + 32'd4;
                    end
                    else
                    begin
                        fault = 1'b1;
                    end
                end
                OP_PUSHL:
                begin
                    if (addr_ok)
                    begin
                        mem_we = 1'b1;
                        wr1_en = 1'b1; wr1_data = addr[31:0];
                    end
                    else
                    begin
                        fault = 1'b1;
                    end
                end
                OP_POPL:
                begin
                    if (addr_ok)
                    begin
                        wr0_en = 1'b1; wr0_data = mem_rval;
                        wr1_en = 1'b1; wr1_data = sp + 32'd4;
                    end
                    else
                    begin
                        fault = 1'b1;
                    end
                end
                OP_PRINTR: begin pv = 1'b1; pval = a_reg; end
                OP_READR:  begin wr0_en = 1'b1; wr0_data = rv_reg; end
                default: ;
            endcase
        end
        if (npc == {14'd0, program_words_reg, 2'b00})
        begin
            halt = 1'b1;
        end
        // drop every write while the item is still waiting
        if (!done)
        begin
            wr0_en = 1'b0;
            wr1_en = 1'b0;
            mem_we = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Operand read for the next item, with forwarding of this cycle's writes
    // ------------------------------------------------------------------
    logic [4:0]  ra_in;
    logic [4:0]  rb_in;
    logic [31:0] a_fwd;
    logic [31:0] b_fwd;

    assign ra_in = s_tdata[26:22];
    assign rb_in = s_tdata[21:17];

    always_comb
    begin
        priority if (wr0_en && wr0_idx == ra_in)        a_fwd = wr0_data;
        else if (wr1_en && ra_in == SP_REG)             a_fwd = wr1_data;
        else if ({1'b0, ra_in} < 6'(REG_COUNT))         a_fwd = rf_reg[ra_in];
        else                                            a_fwd = 32'd0;
        priority if (wr0_en && wr0_idx == rb_in)        b_fwd = wr0_data;
        else if (wr1_en && rb_in == SP_REG)             b_fwd = wr1_data;
        else if ({1'b0, rb_in} < 6'(REG_COUNT))         b_fwd = rf_reg[rb_in];
        else                                            b_fwd = 32'd0;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= (5'(i) == SP_REG) ? 32'(STACK_BYTES) : 32'd0;
            end
            pc_reg        <= 32'd0;
            in_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // commit the finished item; the general write wins over the sp write
            if (wr1_en && !(wr0_en && wr0_idx == SP_REG))
            begin
                rf_reg[SP_REG] <= wr1_data;
            end
            if (wr0_en)
            begin
                rf_reg[wr0_idx] <= wr0_data;
            end
            if (done)
            begin
                pc_reg <= npc;
            end

            // advance the read phase of a stack read
            if (need_read)
            begin
                phase_reg <= 1'b1;
            end
            else if (done)
            begin
                phase_reg <= 1'b0;
            end

            // hold or refill the input stage
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (done)
            begin
                in_valid_reg <= 1'b0;
            end

            // result stage
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            instr_reg <= s_tdata[31:0];
            rv_reg    <= s_tdata[63:32];
            a_reg     <= a_fwd;
            b_reg     <= b_fwd;
        end
        if (done)
        begin
            out_npc_reg   <= npc;
            out_pv_reg    <= pv;
            out_pval_reg  <= pval;
            out_halt_reg  <= halt;
            out_fault_reg <= fault;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_fault_reg, out_halt_reg, out_pval_reg, out_pv_reg, out_npc_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MXIE_ASSERT(a_phase_has_item, !phase_reg || in_valid_reg, "read phase without an item")
    `MXIE_ASSERT_NEXT(a_read_then_phase, need_read, phase_reg, "stack read not followed by phase")
    `MXIE_ASSERT_NEXT(a_fault_keeps_sp, done && fault, rf_reg[SP_REG] == $past(rf_reg[SP_REG]),
                      "faulting item changed sp")

endmodule
